// ----- hdl/pib_pkg.sv -----
`timescale 1ns / 1ps

package pib_pkg;

  localparam int SEL_W       = 9;
  localparam int HIT_INDEX_W = 9;
  localparam int BOX_COUNT_W = 10;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_CLEAR  = 2'd1,
    FUNC_TEST   = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

endpackage

// ----- hdl/pib_ram.sv -----
`timescale 1ns / 1ps

module pib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                            clk,
  input  logic                                            we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr,
  input  logic [WIDTH-1:0]                                wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr,
  output logic [WIDTH-1:0]                                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/pib_box_test.sv -----
`timescale 1ns / 1ps

module pib_box_test #(
  parameter int COORD_BITS = 24
) (
  input  logic [3*COORD_BITS-1:0] pnt,
  input  logic [6*COORD_BITS-1:0] box,
  output logic                    contain
);

  localparam int W  = COORD_BITS;
  localparam int EW = COORD_BITS + 1;

  logic [W-1:0]         cen_a  [3];
  logic [W-1:0]         half_a [3];
  logic [W-1:0]         pnt_a  [3];
  logic signed [EW-1:0] lo     [3];
  logic signed [EW-1:0] hi     [3];
  logic signed [EW-1:0] p_e    [3];
  logic [2:0]           in_axis;

  // Bounds are formed one bit wider than the operands, so the compare is exact.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cen_a[a]   = box[(5 - a) * W +: W];
      half_a[a]  = box[(2 - a) * W +: W];
      pnt_a[a]   = pnt[(2 - a) * W +: W];
      lo[a]      = $signed({cen_a[a][W-1], cen_a[a]}) - $signed({half_a[a][W-1], half_a[a]});
      hi[a]      = $signed({cen_a[a][W-1], cen_a[a]}) + $signed({half_a[a][W-1], half_a[a]});
      p_e[a]     = $signed({pnt_a[a][W-1], pnt_a[a]});
      in_axis[a] = (p_e[a] > lo[a]) && (p_e[a] < hi[a]);
    end
    contain = &in_axis;
  end

endmodule

// ----- hdl/point_in_box_trigger_search.sv -----
`timescale 1ns / 1ps

// Keeps a table of axis-aligned boxes and tests points against it.
// A word is taken at a rising edge where start is high and busy is low; func
// selects append, clear, test or entry read. Each word gives exactly one result
// word, shown for one cycle with done high; the receiver cannot stall it, so it
// must take the result in that cycle.
// Append and clear: result in the cycle after acceptance, busy stays low, so
// one such word can be taken every cycle.
// Entry read: busy for one cycle; the result is set in the read state from the
// registered read of the occupied-bit memory.
// Test: one shared containment unit checks one box per cycle from the box
// memory, starting at entry zero, and stops at the first box that holds the
// point or at the last loaded box. An empty table answers in the next cycle.
// Reset empties the table at once (the box count goes to zero); no clearing
// pass is run, since entries at or above the count are never read as data.
module point_in_box_trigger_search #(
  parameter int MAX_BOXES  = 512,
  parameter int COORD_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  pib_pkg::func_t                     func,
  input  logic signed [COORD_BITS-1:0]       coord_x,
  input  logic signed [COORD_BITS-1:0]       coord_y,
  input  logic signed [COORD_BITS-1:0]       coord_z,
  input  logic signed [COORD_BITS-1:0]       half_x,
  input  logic signed [COORD_BITS-1:0]       half_y,
  input  logic signed [COORD_BITS-1:0]       half_z,
  input  logic [pib_pkg::SEL_W-1:0]          entry_sel,
  output logic                               done,
  output logic                               hit,
  output logic [pib_pkg::HIT_INDEX_W-1:0]    hit_index,
  output logic                               occupied_now,
  output logic                               table_full,
  output logic [pib_pkg::BOX_COUNT_W-1:0]    box_count
);

  import pib_pkg::*;

  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int CMP_W = (CNT_W > SEL_W) ? CNT_W : SEL_W;
  localparam int BOX_W = 6 * COORD_BITS;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_BOXES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ
  } state_t;

  state_t                        state;
  logic [CNT_W-1:0]              count;
  logic [IDX_W-1:0]              iss;
  logic [IDX_W-1:0]              chk;
  logic                          iss_live;
  logic                          chk_vld;
  logic                          sel_ok;
  logic signed [COORD_BITS-1:0]  pnt_x;
  logic signed [COORD_BITS-1:0]  pnt_y;
  logic signed [COORD_BITS-1:0]  pnt_z;

  logic                          accept;
  logic                          box_we;
  logic [BOX_W-1:0]              box_wdata;
  logic [BOX_W-1:0]              box_rdata;
  logic                          occ_we;
  logic [IDX_W-1:0]              occ_waddr;
  logic                          occ_wdata;
  logic [IDX_W-1:0]              occ_raddr;
  logic                          occ_rdata;
  logic                          contain;
  logic                          chk_last;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign chk_last  = ((CNT_W'(chk) + 1'b1) == count);
  assign box_we    = accept && (func == FUNC_APPEND) && (count != FULL_COUNT);
  assign box_wdata = {coord_x, coord_y, coord_z, half_x, half_y, half_z};
  assign occ_raddr = IDX_W'(entry_sel);

  // The scan writes the verdict for each box; an append clears its new entry.
  always_comb begin
    if (state == ST_SCAN) begin
      occ_we    = chk_vld;
      occ_waddr = chk;
      occ_wdata = contain;
    end else begin
      occ_we    = box_we;
      occ_waddr = IDX_W'(count);
      occ_wdata = 1'b0;
    end
  end

  pib_ram #(
    .WIDTH (BOX_W),
    .DEPTH (MAX_BOXES)
  ) u_box_ram (
    .clk   (clk),
    .we    (box_we),
    .waddr (IDX_W'(count)),
    .wdata (box_wdata),
    .raddr (iss),
    .rdata (box_rdata)
  );

  pib_ram #(
    .WIDTH (1),
    .DEPTH (MAX_BOXES)
  ) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (occ_raddr),
    .rdata (occ_rdata)
  );

  pib_box_test #(
    .COORD_BITS (COORD_BITS)
  ) u_box_test (
    .pnt     ({pnt_x, pnt_y, pnt_z}),
    .box     (box_rdata),
    .contain (contain)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      done     <= 1'b0;
      iss_live <= 1'b0;
      chk_vld  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            pnt_x        <= coord_x;
            pnt_y        <= coord_y;
            pnt_z        <= coord_z;
            sel_ok       <= (CMP_W'(entry_sel) < CMP_W'(count));
            iss          <= '0;
            iss_live     <= 1'b1;
            chk_vld      <= 1'b0;
            hit          <= 1'b0;
            hit_index    <= '0;
            occupied_now <= 1'b0;
            table_full   <= 1'b0;
            box_count    <= BOX_COUNT_W'(count);
            unique case (func)
              FUNC_APPEND: begin
                done <= 1'b1;
                if (count == FULL_COUNT) begin
                  table_full <= 1'b1;
                end else begin
                  count     <= count + 1'b1;
                  box_count <= BOX_COUNT_W'(count + 1'b1);
                end
              end
              FUNC_CLEAR: begin
                done      <= 1'b1;
                count     <= '0;
                box_count <= '0;
              end
              FUNC_TEST: begin
                if (count == '0) begin
                  done <= 1'b1;
                end else begin
                  state <= ST_SCAN;
                end
              end
              FUNC_READ: begin
                state <= ST_READ;
              end
            endcase
          end
        end
        ST_SCAN: begin
          chk      <= iss;
          chk_vld  <= iss_live;
          iss      <= iss + 1'b1;
          iss_live <= iss_live && ((CNT_W'(iss) + 1'b1) != count);
          if (chk_vld && (contain || chk_last)) begin
            state     <= ST_IDLE;
            done      <= 1'b1;
            hit       <= contain;
            hit_index <= contain ? HIT_INDEX_W'(chk) : '0;
          end
        end
        ST_READ: begin
          occupied_now <= sel_ok && occ_rdata;
          done         <= 1'b1;
          state        <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("box count above table depth");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_hit_in_table: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (CNT_W'(hit_index) < count))
    else $error("hit index beyond loaded boxes");

  a_full_only_at_depth: assert property (@(posedge clk) disable iff (rst)
    (done && table_full) |-> (count == FULL_COUNT))
    else $error("append rejected with room left");

  a_check_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && chk_vld) |-> (CNT_W'(chk) < count))
    else $error("scan checks an unloaded entry");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import pib_pkg::*;

  localparam int TABLE_DEPTH  = 512;
  localparam int CW           = 24;
  localparam int RANDOM_WORDS = 630;
  localparam int STALL_LIMIT  = 4000;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [SEL_W-1:0] sel_t;

  localparam coord_t C_MAX = 24'sh7FFFFF;
  localparam coord_t C_MIN = 24'sh800000;

  typedef struct packed {
    logic                   hit;
    logic [HIT_INDEX_W-1:0] hit_index;
    logic                   occupied_now;
    logic                   table_full;
    logic [BOX_COUNT_W-1:0] box_count;
  } lookup_result_t;

  class box_lookup_board;
    coord_t centre_x[TABLE_DEPTH];
    coord_t centre_y[TABLE_DEPTH];
    coord_t centre_z[TABLE_DEPTH];
    coord_t half_x[TABLE_DEPTH];
    coord_t half_y[TABLE_DEPTH];
    coord_t half_z[TABLE_DEPTH];
    bit occupied[TABLE_DEPTH];
    int loaded;
    lookup_result_t awaited_results[$];
    int mismatches;
    int results_seen;
    int hits_seen;
    int full_rejects;
    int words_by_func[4];

    function bit axis_holds(coord_t p, coord_t c, coord_t h);
      longint lo, hi;
      lo = longint'(c) - longint'(h);
      hi = longint'(c) + longint'(h);
      return (longint'(p) > lo) && (longint'(p) < hi);
    endfunction

    function void take_word(func_t f, coord_t x, coord_t y, coord_t z,
                            coord_t hx, coord_t hy, coord_t hz, sel_t sel);
      lookup_result_t r;
      r = '0;
      words_by_func[int'(f)]++;
      case (f)
        FUNC_APPEND: begin
          if (loaded >= TABLE_DEPTH) begin
            r.table_full = 1'b1;
            full_rejects++;
          end else begin
            centre_x[loaded] = x;
            centre_y[loaded] = y;
            centre_z[loaded] = z;
            half_x[loaded] = hx;
            half_y[loaded] = hy;
            half_z[loaded] = hz;
            occupied[loaded] = 1'b0;
            loaded++;
          end
        end
        FUNC_CLEAR: begin
          loaded = 0;
          foreach (occupied[k]) occupied[k] = 1'b0;
        end
        FUNC_TEST: begin
          // Boxes walked past without a hit lose their occupied bit.
          for (int i = 0; i < loaded; i++) begin
            if (axis_holds(x, centre_x[i], half_x[i]) &&
                axis_holds(y, centre_y[i], half_y[i]) &&
                axis_holds(z, centre_z[i], half_z[i])) begin
              occupied[i] = 1'b1;
              r.hit = 1'b1;
              r.hit_index = HIT_INDEX_W'(i);
              hits_seen++;
              break;
            end
            occupied[i] = 1'b0;
          end
        end
        default: r.occupied_now = occupied[sel];
      endcase
      r.box_count = BOX_COUNT_W'(loaded);
      awaited_results.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: mismatch in %s at result word %0d: got %0d, expected %0d",
                 $time, what, results_seen, got, want);
    endtask

    task check_result(lookup_result_t got);
      lookup_result_t want;
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch("result word with nothing awaited", 1, 0);
        return;
      end
      want = awaited_results.pop_front();
      if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
      if (got.hit_index !== want.hit_index)
        report_mismatch("hit_index", got.hit_index, want.hit_index);
      if (got.occupied_now !== want.occupied_now)
        report_mismatch("occupied_now", got.occupied_now, want.occupied_now);
      if (got.table_full !== want.table_full)
        report_mismatch("table_full", got.table_full, want.table_full);
      if (got.box_count !== want.box_count)
        report_mismatch("box_count", got.box_count, want.box_count);
    endtask
  endclass

  bit clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  func_t func;
  coord_t coord_x, coord_y, coord_z;
  coord_t half_x, half_y, half_z;
  sel_t entry_sel;
  logic done;
  logic hit;
  logic [HIT_INDEX_W-1:0] hit_index;
  logic occupied_now;
  logic table_full;
  logic [BOX_COUNT_W-1:0] box_count;

  box_lookup_board board = new();

  int idle_cycles;
  int words_sent;
  int burst_left;
  int shadow_count;
  coord_t shadow_cx[TABLE_DEPTH];
  coord_t shadow_cy[TABLE_DEPTH];
  coord_t shadow_cz[TABLE_DEPTH];
  coord_t shadow_hx[TABLE_DEPTH];
  coord_t shadow_hy[TABLE_DEPTH];
  coord_t shadow_hz[TABLE_DEPTH];

  point_in_box_trigger_search dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .coord_x(coord_x),
    .coord_y(coord_y),
    .coord_z(coord_z),
    .half_x(half_x),
    .half_y(half_y),
    .half_z(half_z),
    .entry_sel(entry_sel),
    .done(done),
    .hit(hit),
    .hit_index(hit_index),
    .occupied_now(occupied_now),
    .table_full(table_full),
    .box_count(box_count)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        board.take_word(func, coord_x, coord_y, coord_z, half_x, half_y, half_z, entry_sel);
      if (done)
        board.check_result({hit, hit_index, occupied_now, table_full, box_count});
      if ((start && !busy) || done) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("point_in_box_trigger_search regression: fail");
          $finish;
        end
      end
    end
  end

  function automatic coord_t any_coord();
    return coord_t'($urandom);
  endfunction

  function automatic coord_t tight_coord();
    return coord_t'(int'($urandom_range(0, 6000)) - 3000);
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > longint'(C_MAX)) return C_MAX;
    if (v < longint'(C_MIN)) return C_MIN;
    return coord_t'(v);
  endfunction

  function automatic coord_t inside_offset(coord_t c, coord_t h);
    longint off;
    if (h <= 1) return c;
    off = longint'($urandom_range(0, 2 * (int'(h) - 1))) - (longint'(h) - 1);
    return clamp_coord(longint'(c) + off);
  endfunction

  function automatic coord_t pick_half(bit tight);
    case ($urandom_range(0, 47))
      0: return '0;
      1: return coord_t'(-int'($urandom_range(1, 5000)));
      2: return any_coord();
      default: return tight ? coord_t'($urandom_range(200, 2500))
                            : coord_t'($urandom_range(1, 1 << $urandom_range(0, 22)));
    endcase
  endfunction

  task automatic send_word(func_t f, coord_t x, coord_t y, coord_t z,
                           coord_t hx, coord_t hy, coord_t hz, sel_t sel);
    @(negedge clk);
    func = f;
    coord_x = x;
    coord_y = y;
    coord_z = z;
    half_x = hx;
    half_y = hy;
    half_z = hz;
    entry_sel = sel;
    start = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 100)
                                                : $urandom_range(1, 10);
    end
  endtask

  task automatic append_box(coord_t x, coord_t y, coord_t z,
                            coord_t hx, coord_t hy, coord_t hz);
    send_word(FUNC_APPEND, x, y, z, hx, hy, hz, sel_t'($urandom));
    if (shadow_count < TABLE_DEPTH) begin
      shadow_cx[shadow_count] = x;
      shadow_cy[shadow_count] = y;
      shadow_cz[shadow_count] = z;
      shadow_hx[shadow_count] = hx;
      shadow_hy[shadow_count] = hy;
      shadow_hz[shadow_count] = hz;
      shadow_count++;
    end
  endtask

  task automatic clear_table();
    send_word(FUNC_CLEAR, any_coord(), any_coord(), any_coord(),
              any_coord(), any_coord(), any_coord(), sel_t'($urandom));
    shadow_count = 0;
  endtask

  task automatic test_point(coord_t x, coord_t y, coord_t z);
    send_word(FUNC_TEST, x, y, z, any_coord(), any_coord(), any_coord(), sel_t'($urandom));
  endtask

  task automatic read_entry(sel_t sel);
    send_word(FUNC_READ, any_coord(), any_coord(), any_coord(),
              any_coord(), any_coord(), any_coord(), sel);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (board.awaited_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    int seq;
    int j;
    bit tight;
    func_t f;
    coord_t px, py, pz;

    rst = 1'b1;
    start = 1'b0;
    func = FUNC_APPEND;
    coord_x = '0;
    coord_y = '0;
    coord_z = '0;
    half_x = '0;
    half_y = '0;
    half_z = '0;
    entry_sel = '0;
    burst_left = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // A test on an empty table, reads of untouched entries, boxes at the
    // coordinate extremes, zero and negative half sizes, and points lying
    // exactly on a face.
    test_point('0, '0, '0);
    read_entry('0);
    read_entry(sel_t'(TABLE_DEPTH - 1));
    append_box(C_MAX, C_MAX, C_MAX, coord_t'(1), coord_t'(1), coord_t'(1));
    append_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
    append_box('0, '0, '0, '0, coord_t'(5), coord_t'(5));
    append_box('0, '0, '0, coord_t'(-3), coord_t'(-3), coord_t'(-3));
    append_box(coord_t'(100), coord_t'(100), coord_t'(100),
               coord_t'(10), coord_t'(10), coord_t'(10));
    test_point(C_MAX, C_MAX, C_MAX);
    test_point(C_MIN, C_MIN, C_MIN);
    read_entry(sel_t'(0));
    read_entry(sel_t'(1));
    test_point(coord_t'(110), coord_t'(100), coord_t'(100));
    test_point(coord_t'(109), coord_t'(91), coord_t'(100));
    read_entry(sel_t'(4));
    read_entry(sel_t'(300));
    test_point(coord_t'(90), coord_t'(100), coord_t'(100));
    test_point('0, '0, '0);
    clear_table();
    read_entry(sel_t'(4));
    test_point(coord_t'(100), coord_t'(100), coord_t'(100));
    shadow_count = 0;

    seq = 0;
    while (words_sent < RANDOM_WORDS) begin
      seq++;
      if (seq % 12 == 1) wait_drained();
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          f = func_t'($urandom_range(0, 3));
          case (f)
            FUNC_APPEND: append_box(any_coord(), any_coord(), any_coord(),
                                    any_coord(), any_coord(), any_coord());
            FUNC_CLEAR: clear_table();
            FUNC_TEST: test_point(any_coord(), any_coord(), any_coord());
            default: read_entry(sel_t'($urandom));
          endcase
        end
      end else begin
        if (shadow_count > 48 || $urandom_range(0, 2) == 0) clear_table();
        tight = $urandom_range(0, 1);
        repeat ($urandom_range(1, 10)) begin
          if (tight)
            append_box(tight_coord(), tight_coord(), tight_coord(),
                       pick_half(1'b1), pick_half(1'b1), pick_half(1'b1));
          else
            append_box(any_coord(), any_coord(), any_coord(),
                       pick_half(1'b0), pick_half(1'b0), pick_half(1'b0));
        end
        repeat ($urandom_range(1, 8)) begin
          if (shadow_count > 0 && $urandom_range(0, 9) < 7) begin
            j = $urandom_range(0, shadow_count - 1);
            px = inside_offset(shadow_cx[j], shadow_hx[j]);
            py = inside_offset(shadow_cy[j], shadow_hy[j]);
            pz = inside_offset(shadow_cz[j], shadow_hz[j]);
            case ($urandom_range(0, 9))
              0: px = clamp_coord(longint'(shadow_cx[j]) + longint'(shadow_hx[j]));
              1: pz = clamp_coord(longint'(shadow_cz[j]) - longint'(shadow_hz[j]));
              default: ;
            endcase
          end else if (tight) begin
            px = tight_coord();
            py = tight_coord();
            pz = tight_coord();
          end else begin
            px = any_coord();
            py = any_coord();
            pz = any_coord();
          end
          test_point(px, py, pz);
        end
        repeat ($urandom_range(0, 3)) begin
          if (shadow_count > 0 && $urandom_range(0, 3) != 0)
            read_entry(sel_t'($urandom_range(0, shadow_count - 1)));
          else
            read_entry(sel_t'($urandom));
        end
      end
    end

    // Fill the table to the brim, push three more boxes against it, then walk
    // it end to end.
    wait_drained();
    clear_table();
    for (int k = 0; k < TABLE_DEPTH + 3; k++)
      append_box(coord_t'(k * 64), coord_t'(-k * 64), coord_t'(k),
                 coord_t'(20), coord_t'(20), coord_t'(20));
    test_point(coord_t'(511 * 64), coord_t'(-511 * 64), coord_t'(511));
    read_entry(sel_t'(TABLE_DEPTH - 1));
    read_entry(sel_t'(0));
    test_point(coord_t'(5), coord_t'(-3), coord_t'(1));
    test_point(coord_t'(300 * 64 + 7), coord_t'(-300 * 64), coord_t'(300));
    read_entry(sel_t'(300));
    read_entry(sel_t'(0));
    test_point(C_MIN, C_MAX, '0);
    read_entry(sel_t'(300));
    clear_table();
    test_point('0, '0, '0);
    read_entry(sel_t'(TABLE_DEPTH - 1));

    wait_drained();
    repeat (8) @(negedge clk);
    if (board.awaited_results.size() != 0)
      board.report_mismatch("result words never delivered", 0, board.awaited_results.size());

    $display("Sent %0d words: %0d appends (%0d refused on a full table), %0d clears,",
             words_sent, board.words_by_func[FUNC_APPEND], board.full_rejects,
             board.words_by_func[FUNC_CLEAR]);
    $display("%0d point tests with %0d hits, %0d entry reads; %0d result words, %0d mismatches.",
             board.words_by_func[FUNC_TEST], board.hits_seen, board.words_by_func[FUNC_READ],
             board.results_seen, board.mismatches);
    if (board.mismatches == 0) begin
      $display("point_in_box_trigger_search regression: pass");
    end else begin
      $display("point_in_box_trigger_search regression: fail");
    end
    $finish;
  end

endmodule
